### rtl/cas_att_pkg.sv
// Package with the shared constants, types and divide helpers of the attenuator split.
package cas_att_pkg;

  localparam int STAGE_BITS = 7;
  localparam int STEP_HUNDREDTHS = 25;
  localparam int STAGE_MAX_INT = ((1 << STAGE_BITS) - 1) * STEP_HUNDREDTHS;

  localparam int TOTAL_W = 16;
  localparam int EXCESS_W = 15;
  localparam int DAC_W = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [TOTAL_W-1:0] STAGE_MAX = TOTAL_W'(STAGE_MAX_INT);
  localparam logic [DAC_W-1:0] DAC_LIMIT_RESET = DAC_W'(2300);

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_BF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_AF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAC_LIMIT = 2'd2;

  // Reciprocal multiplier shared by the divide-by-25 (shift 20) and the
  // divide-by-100 (shift 22) paths; both are exact for operands below 43690.
  localparam logic [15:0] DIV_MULT = 16'd41944;
  localparam int SHIFT_25 = 20;
  localparam int SHIFT_100 = 22;
  localparam int PROD_W = EXCESS_W + 16;

  typedef logic [STAGE_BITS-1:0] code_t;

  typedef struct packed {
    logic                       channel;
    logic signed [TOTAL_W-1:0] total_att;
    logic                       controller_on;
  } req_t;

  function automatic code_t div25(input logic [EXCESS_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(DIV_MULT);
    return prod[SHIFT_25 +: STAGE_BITS];
  endfunction

  function automatic logic [8:0] div100(input logic [EXCESS_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(DIV_MULT);
    return prod[SHIFT_100 +: 9];
  endfunction

  // Clamp to 0..STAGE_MAX, then one code step per 0.25 dB.
  function automatic code_t stage_code(input logic signed [TOTAL_W-1:0] v);
    logic [EXCESS_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > STAGE_MAX) begin
      c = STAGE_MAX[EXCESS_W-1:0];
    end else begin
      c = v[EXCESS_W-1:0];
    end
    return div25(c);
  endfunction

endpackage

### rtl/cascaded_attenuator_split.sv
// Top level of the cascaded attenuator split: floor handling, stage codes and gain voltage.
//
//   channel   | direction | handshake             | contents
//   ----------+-----------+-----------------------+------------------------------------------
//   in_       | input     | in_valid / in_ready   | channel, total_att, controller_on
//   out_      | output    | out_valid / out_ready | channel, codes, excess, dac, total, raise
//   cfg_      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Each transaction is captured in an input register, resolved by one pass of
// short logic and written to the result register, and one transaction can be
// accepted every cycle while the result is not stalled. The stored totals, the gain
// voltage and the floor-cleared bits are updated as the result is registered.
// Reset is synchronous and active low; it empties both stages and restores the
// configuration registers and the stored state. A stalled result holds the
// result register, and the input register then holds its transaction too.
module cascaded_attenuator_split (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_channel,
  input  logic signed [cas_att_pkg::TOTAL_W-1:0] in_total_att,
  input  logic                                   in_controller_on,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_channel,
  output logic [cas_att_pkg::STAGE_BITS-1:0]     out_first_code,
  output logic [cas_att_pkg::STAGE_BITS-1:0]     out_second_code,
  output logic [cas_att_pkg::EXCESS_W-1:0]       out_second_att,
  output logic [cas_att_pkg::DAC_W-1:0]          out_dac_mv,
  output logic signed [cas_att_pkg::TOTAL_W-1:0] out_applied_total,
  output logic                                   out_gain_raise,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cas_att_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cas_att_pkg::TOTAL_W-1:0]        cfg_data
);
  import cas_att_pkg::*;

  // Configuration registers.
  logic signed [TOTAL_W-1:0] floor_r [2];
  logic [DAC_W-1:0]          dac_limit_r;

  // State carried from one transaction to the next.
  logic signed [TOTAL_W-1:0] prev_total_r [2];
  logic [DAC_W-1:0]          prev_dac_r;
  logic [1:0]                floor_cleared_r;
  logic [1:0]                floor_cleared_nxt;

  // Input register.
  logic s1_valid_r;
  req_t s1_req_r;
  logic s1_adv;

  // Result register.
  logic                      out_valid_r;
  logic                      res_channel_r;
  code_t                     res_first_r;
  code_t                     res_second_r;
  logic [EXCESS_W-1:0]       res_excess_r;
  logic [DAC_W-1:0]          res_dac_r;
  logic signed [TOTAL_W-1:0] res_total_r;
  logic                      res_raise_r;

  // Resolved values of the transaction in the input register.
  logic                      ch;
  logic                      neg_clear;
  logic                      cleared_now;
  logic signed [TOTAL_W-1:0] t_req;
  logic signed [TOTAL_W-1:0] floor_eff;
  logic signed [TOTAL_W-1:0] t_app;
  logic                      over;
  logic signed [TOTAL_W-1:0] excess_full;
  logic [EXCESS_W-1:0]       excess;
  logic                      raise;
  logic [8:0]                q_floor;
  logic [8:0]                q_ceil;
  logic [DAC_W:0]            mv_up;
  logic [DAC_W-1:0]          mv_down;
  logic [DAC_W:0]            mv_sat_in;
  logic [DAC_W-1:0]          mv;
  code_t                     first_nxt;
  code_t                     second_nxt;
  logic [EXCESS_W-1:0]       excess_nxt;
  logic [DAC_W-1:0]          dac_nxt;
  logic                      raise_nxt;

  // The result register frees up when it is empty or being read this cycle;
  // the input register can then pass its transaction along and take a new one.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ch = s1_req_r.channel;

    // A negative request with the controller on clears the channel's floor
    // and is applied as zero; otherwise the request is raised to the floor.
    neg_clear   = (s1_req_r.total_att < 0) && s1_req_r.controller_on;
    cleared_now = floor_cleared_r[ch] || neg_clear;
    t_req       = neg_clear ? '0 : s1_req_r.total_att;
    floor_eff   = cleared_now ? '0 : floor_r[ch];
    t_app       = (t_req < floor_eff) ? floor_eff : t_req;

    over        = t_app > STAGE_MAX;
    excess_full = t_app - STAGE_MAX;
    excess      = over ? excess_full[EXCESS_W-1:0] : '0;
    raise       = t_app < prev_total_r[0];

    // Gain voltage: (prev*100 +/- excess) / 100 truncated. Going up this is
    // prev + floor(excess/100); going down it is prev - ceil(excess/100),
    // saturated at zero; the result is then capped at the DAC limit.
    q_floor   = div100(excess);
    q_ceil    = div100(excess + EXCESS_W'(99));
    mv_up     = (DAC_W+1)'(prev_dac_r) + (DAC_W+1)'(q_floor);
    mv_down   = ((DAC_W+1)'(prev_dac_r) >= (DAC_W+1)'(q_ceil)) ?
                (prev_dac_r - DAC_W'(q_ceil)) : '0;
    mv_sat_in = raise ? (DAC_W+1)'(mv_down) : mv_up;
    mv        = (mv_sat_in > (DAC_W+1)'(dac_limit_r)) ? dac_limit_r : mv_sat_in[DAC_W-1:0];

    first_nxt  = stage_code(t_app);
    second_nxt = '0;
    excess_nxt = '0;
    dac_nxt    = '0;
    raise_nxt  = 1'b0;
    if (!ch) begin
      // Single-stage channel: anything above the stage range moves the gain
      // voltage, and a total within range parks the voltage at zero.
      raise_nxt = raise;
      dac_nxt   = over ? mv : '0;
    end else if (over) begin
      // Two-stage channel: the excess goes to the second stage.
      second_nxt = stage_code(excess_full);
      excess_nxt = excess;
    end

    floor_cleared_nxt = floor_cleared_r;
    if (s1_adv && neg_clear) begin
      floor_cleared_nxt[ch] = 1'b1;
    end
    // Rewriting a floor makes it count again.
    if (cfg_valid && (cfg_index == REG_FLOOR_BF)) begin
      floor_cleared_nxt[0] = 1'b0;
    end
    if (cfg_valid && (cfg_index == REG_FLOOR_AF)) begin
      floor_cleared_nxt[1] = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      floor_r[0]      <= '0;
      floor_r[1]      <= '0;
      dac_limit_r     <= DAC_LIMIT_RESET;
      prev_total_r[0] <= '0;
      prev_total_r[1] <= '0;
      prev_dac_r      <= '0;
      floor_cleared_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      floor_cleared_r <= floor_cleared_nxt;

      if (s1_adv) begin
        prev_total_r[ch] <= t_app;
        if (!ch) begin
          prev_dac_r <= dac_nxt;
        end
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FLOOR_BF:  floor_r[0]  <= cfg_data;
          REG_FLOOR_AF:  floor_r[1]  <= cfg_data;
          REG_DAC_LIMIT: dac_limit_r <= cfg_data[DAC_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r.channel       <= in_channel;
      s1_req_r.total_att     <= in_total_att;
      s1_req_r.controller_on <= in_controller_on;
    end
    if (s1_adv) begin
      res_channel_r <= ch;
      res_first_r   <= first_nxt;
      res_second_r  <= second_nxt;
      res_excess_r  <= excess_nxt;
      res_dac_r     <= dac_nxt;
      res_total_r   <= t_app;
      res_raise_r   <= raise_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = res_channel_r;
  assign out_first_code    = res_first_r;
  assign out_second_code   = res_second_r;
  assign out_second_att    = res_excess_r;
  assign out_dac_mv        = res_dac_r;
  assign out_applied_total = res_total_r;
  assign out_gain_raise    = res_raise_r;

endmodule
